>>> hw/rtl/rbm_pkg.sv
// Package for the rotated block-move row addresser.
// Types, widths, register indexes and limits shared by all RTL files but the checker; no dependencies.
`default_nettype none

package rbm_pkg;

	localparam int MaxRes   = 4096;
	localparam int CoordW   = 16;
	localparam int AddrW    = 32;
	localparam int LenW     = 13;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	localparam int InDataW  = 88;
	localparam int OutDataW = 96;

	localparam logic [CfgIdxW-1:0] RegRotateCw  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCanvasX   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCanvasY   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegFrameBase = 3'd3;
	localparam logic [CfgIdxW-1:0] RegRowPitch  = 3'd4;

	typedef struct packed {
		logic               rotate_cw;
		logic [12:0]        canvas_x_res;
		logic [12:0]        canvas_y_res;
		logic [AddrW-1:0]   frame_base;
		logic [13:0]        row_pitch;
	} cfg_t;

	typedef struct packed {
		logic [11:0]        row_index;
		logic signed [12:0] shift_y;
		logic signed [12:0] shift_x;
		logic [11:0]        rect_bottom;
		logic [11:0]        rect_right;
		logic [11:0]        rect_top;
		logic [11:0]        rect_left;
	} item_t;

	typedef struct packed {
		logic signed [CoordW-1:0] src_row;
		logic signed [CoordW-1:0] dst_row;
		logic signed [CoordW-1:0] src_col;
		logic signed [CoordW-1:0] dst_col;
		logic [LenW-1:0]          copy_length;
		logic [LenW-1:0]          row_count;
		logic                     copy_backward;
		logic                     row_valid;
	} row_desc_t;

	typedef struct packed {
		logic [AddrW-1:0] src_addr;
		logic [AddrW-1:0] dst_addr;
		logic [LenW-1:0]  copy_length;
		logic             copy_backward;
		logic [LenW-1:0]  row_count;
		logic             row_valid;
	} result_t;

	typedef struct packed {
		logic en_s3;
		logic en_out;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rbm_map.sv
// Rotation mapping and move selection: logical rectangle to physical row descriptor.
// Purely combinational; uses rbm_pkg types.
`default_nettype none

module rbm_map (
	input  rbm_pkg::item_t     item,
	input  rbm_pkg::cfg_t      cfg,
	output rbm_pkg::row_desc_t desc
);

	logic signed [rbm_pkg::CoordW-1:0] l, t, r, b, cx, cy, px, py, idx;
	logic signed [rbm_pkg::CoordW-1:0] pl, pr, pt, pb, len, rows;
	logic signed [rbm_pkg::CoordW-1:0] srow, drow, scol, dcol;
	logic                              back, upward, valid;

	always_comb begin
		l   = $signed({4'b0000, item.rect_left});
		t   = $signed({4'b0000, item.rect_top});
		r   = $signed({4'b0000, item.rect_right});
		b   = $signed({4'b0000, item.rect_bottom});
		idx = $signed({4'b0000, item.row_index});
		cx  = $signed({3'b000, cfg.canvas_x_res});
		cy  = $signed({3'b000, cfg.canvas_y_res});
		px  = $signed({{3{item.shift_y[12]}}, item.shift_y});
		py  = $signed({{3{item.shift_x[12]}}, item.shift_x});

		if (cfg.rotate_cw) begin
			pl = t;
			pr = b;
			pt = cx - r - 16'sd1;
			pb = cx - l - 16'sd1;
			py = -py;
		end else begin
			pl = cy - b - 16'sd1;
			pr = cy - t - 16'sd1;
			pt = l;
			pb = r;
			px = -px;
		end

		upward = 1'b0;
		if (px != 16'sd0) begin
			back = px > 16'sd0;
			if (px > 16'sd0) begin
				dcol = pl + px;
				scol = pl;
				len  = pr - pl + 16'sd1 - px;
			end else begin
				dcol = pl;
				scol = pl - px;
				len  = pr - pl + 16'sd1 + px;
			end
			rows = pb - pt + 16'sd1;
			srow = pt;
			drow = pt;
		end else begin
			len  = pr - pl + 16'sd1;
			scol = pl;
			dcol = pl;
			back = py > 16'sd0;
			if (py > 16'sd0) begin
				drow   = pb;
				srow   = pb - py;
				rows   = pb - pt + 16'sd1 - py;
				upward = 1'b1;
			end else begin
				drow = pt;
				srow = pt - py;
				rows = pb - pt + 16'sd1 + py;
			end
		end

		if (len <= 16'sd0 || rows <= 16'sd0) begin
			len  = 16'sd0;
			rows = 16'sd0;
		end
		if (len > 16'(rbm_pkg::MaxRes))
			len = 16'(rbm_pkg::MaxRes);
		if (rows > 16'(rbm_pkg::MaxRes))
			rows = 16'(rbm_pkg::MaxRes);

		valid = idx < rows;

		desc.src_row       = upward ? srow - idx : srow + idx;
		desc.dst_row       = upward ? drow - idx : drow + idx;
		desc.src_col       = scol;
		desc.dst_col       = dcol;
		desc.copy_length   = len[rbm_pkg::LenW-1:0];
		desc.row_count     = rows[rbm_pkg::LenW-1:0];
		desc.copy_backward = back;
		desc.row_valid     = valid;
	end

endmodule

`default_nettype wire

>>> hw/rtl/rbm_addr.sv
// Address stages: row times pitch, then base plus offset plus column into the result register.
// Uses rbm_pkg types; stage enables come from the top level.
`default_nettype none

module rbm_addr (
	input  wire                           clk,
	input  rbm_pkg::pipe_ctrl_t           ctrl,
	input  rbm_pkg::row_desc_t            desc,
	input  wire [rbm_pkg::AddrW-1:0]      frame_base,
	input  wire [13:0]                    row_pitch,
	output rbm_pkg::result_t              res
);

	logic signed [30:0]             src_prod, dst_prod;
	logic [rbm_pkg::AddrW-1:0]      src_prod_s3, dst_prod_s3;
	rbm_pkg::row_desc_t             desc_s3;
	rbm_pkg::result_t               res_q;

	assign src_prod = desc.src_row * $signed({1'b0, row_pitch});
	assign dst_prod = desc.dst_row * $signed({1'b0, row_pitch});

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			src_prod_s3 <= {src_prod[30], src_prod};
			dst_prod_s3 <= {dst_prod[30], dst_prod};
			desc_s3     <= desc;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_out) begin
			res_q.row_count <= desc_s3.row_count;
			res_q.row_valid <= desc_s3.row_valid;
			if (desc_s3.row_valid) begin
				res_q.src_addr      <= frame_base + src_prod_s3
					+ {{16{desc_s3.src_col[15]}}, desc_s3.src_col};
				res_q.dst_addr      <= frame_base + dst_prod_s3
					+ {{16{desc_s3.dst_col[15]}}, desc_s3.dst_col};
				res_q.copy_length   <= desc_s3.copy_length;
				res_q.copy_backward <= desc_s3.copy_backward;
			end else begin
				res_q.src_addr      <= '0;
				res_q.dst_addr      <= '0;
				res_q.copy_length   <= '0;
				res_q.copy_backward <= 1'b0;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/rotated_block_move_row_addresser_top.sv
// Rotated block-move row addresser, top level.
// Holds configuration registers, input and descriptor stages; uses rbm_pkg, rbm_map, rbm_addr.
//
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//   Write registers only while no beat is in flight.
//   s_ channel: one beat per row request (rectangle, shifts, row index).
//   m_ channel: one beat per request with source/destination addresses, length,
//   direction and row count; m_tuser carries the row-valid flag.
//   Stages, in order: input register, mapping, multiply by pitch, address add.
//   Throughput: one beat per cycle while the output is not stalled; the four
//   stages each hold one beat.
//   Stall: a stage empties forward whenever the one after it is free, so input
//   keeps being taken until all four stages hold beats while m_tready is low.
//   Reset: pipeline empties, registers return to clockwise, 320 x 240, base 0,
//   pitch 240.
`default_nettype none

module rotated_block_move_row_addresser_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [rbm_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire [rbm_pkg::CfgDataW-1:0]      cfg_data,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// rect_left, rect_top, rect_right, rect_bottom, shift_x, shift_y, row_index, zero pad
	input  wire [rbm_pkg::InDataW-1:0]       s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// src_addr, dst_addr, copy_length, copy_backward, row_count, zero pad
	output logic [rbm_pkg::OutDataW-1:0]     m_tdata,
	// row_valid
	output logic                             m_tuser
);

	rbm_pkg::cfg_t       cfg_q;
	rbm_pkg::item_t      item_s1;
	rbm_pkg::row_desc_t  desc, desc_s2;
	rbm_pkg::result_t    res;
	rbm_pkg::pipe_ctrl_t ctrl;
	logic                v_s1, v_s2, v_s3, v_out_q;
	logic                en_s1, en_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotate_cw    <= 1'b1;
			cfg_q.canvas_x_res <= 13'd320;
			cfg_q.canvas_y_res <= 13'd240;
			cfg_q.frame_base   <= '0;
			cfg_q.row_pitch    <= 14'd240;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbm_pkg::RegRotateCw:  cfg_q.rotate_cw    <= cfg_data[0];
				rbm_pkg::RegCanvasX:   cfg_q.canvas_x_res <= cfg_data[12:0];
				rbm_pkg::RegCanvasY:   cfg_q.canvas_y_res <= cfg_data[12:0];
				rbm_pkg::RegFrameBase: cfg_q.frame_base   <= cfg_data;
				rbm_pkg::RegRowPitch:  cfg_q.row_pitch    <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// stage enables, bubbles collapse
	assign ctrl.en_out = !v_out_q || m_tready;
	assign ctrl.en_s3  = !v_s3 || ctrl.en_out;
	assign en_s2       = !v_s2 || ctrl.en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign s_tready    = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= s_tvalid;
			if (en_s2)
				v_s2 <= v_s1;
			if (ctrl.en_s3)
				v_s3 <= v_s2;
			if (ctrl.en_out)
				v_out_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1.rect_left   <= s_tdata[11:0];
			item_s1.rect_top    <= s_tdata[23:12];
			item_s1.rect_right  <= s_tdata[35:24];
			item_s1.rect_bottom <= s_tdata[47:36];
			item_s1.shift_x     <= $signed(s_tdata[60:48]);
			item_s1.shift_y     <= $signed(s_tdata[73:61]);
			item_s1.row_index   <= s_tdata[85:74];
		end
		if (en_s2)
			desc_s2 <= desc;
	end

	rbm_map u_map (
		.item (item_s1),
		.cfg  (cfg_q),
		.desc (desc)
	);

	rbm_addr u_addr (
		.clk        (clk),
		.ctrl       (ctrl),
		.desc       (desc_s2),
		.frame_base (cfg_q.frame_base),
		.row_pitch  (cfg_q.row_pitch),
		.res        (res)
	);

	assign m_tvalid = v_out_q;
	assign m_tdata  = {5'b00000, res.row_count, res.copy_backward, res.copy_length,
		res.dst_addr, res.src_addr};
	assign m_tuser  = res.row_valid;

endmodule

`default_nettype wire

>>> hw/rtl/rbm_checker.sv
// Port-level checker for the rotated block-move row addresser, bound to the top level.
// Sees only top-level ports; no package dependency.
`default_nettype none

module rbm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata,
	input wire        m_tuser
);

	// a stalled result beat stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat dropped or changed under stall");

	// input is held off only behind a stalled result beat
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	// an invalid row carries no addresses, length or direction
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[77:0] == 78'd0)
		else $error("invalid row with nonzero fields");

	// a valid row has a nonempty move
	a_valid_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[76:64] != 13'd0 && m_tdata[90:78] != 13'd0)
		else $error("valid row with empty move");

	// length and row count saturate
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[76:64] <= 13'd4096 && m_tdata[90:78] <= 13'd4096)
		else $error("length or row count above limit");

endmodule

bind rotated_block_move_row_addresser_top rbm_checker u_rbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

`default_nettype wire
